[rtl/lrsp_pkg.sv]
// Package for the LED ring spotlight profile: types, sizes and constant tables.
// The cosine-match and blur tables are computed at elaboration from a fixed-point Taylor series.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps

package lrsp_pkg;

  // LEDs served by one request (one half of a ring).
  localparam int unsigned LEDS_PER_SEGMENT = 12;

  localparam int unsigned K_W       = $clog2(LEDS_PER_SEGMENT);
  localparam int unsigned IDX_W     = $clog2(2 * LEDS_PER_SEGMENT);
  localparam int unsigned LED_IDX_W = 5;
  localparam int unsigned DEG_W     = 9;
  localparam int unsigned WIDTH_W   = 10;
  localparam int unsigned C_W       = 17;
  localparam int unsigned BLUR_W    = 32;
  localparam int unsigned PROD_W    = C_W + BLUR_W;
  localparam int unsigned M_W       = PROD_W - 14;
  localparam int unsigned V_W       = 17;
  localparam int unsigned VP_W      = V_W + 8;

  localparam int unsigned DEG_TURN  = 360;
  localparam int unsigned LED_STEP  = DEG_TURN / LEDS_PER_SEGMENT;
  localparam int unsigned LED_FIRST = 15;
  localparam int unsigned N_WIDTHS  = 1 << WIDTH_W;

  localparam logic [C_W-1:0]      QONE      = C_W'(65536);
  localparam logic [IDX_W-1:0]    HALF_BASE = IDX_W'(LEDS_PER_SEGMENT);
  localparam logic [K_W-1:0]      K_LAST    = K_W'(LEDS_PER_SEGMENT - 1);
  localparam logic [DEG_W-1:0]    TURN_DEG  = DEG_W'(DEG_TURN);

  localparam longint unsigned RAD_PER_QDEG_Q30 = 64'd4685083;
  localparam longint unsigned COS_DIV [1:6] = '{2, 12, 30, 56, 90, 132};

  typedef struct packed {
    logic [1:0]         ring_segment;
    logic [9:0]         hue;
    logic [7:0]         saturation;
    logic [DEG_W-1:0]   center_angle;
    logic [WIDTH_W-1:0] spot_width;
    logic [7:0]         peak_brightness;
  } req_t;

  typedef struct packed {
    logic                 ring_select;
    logic [LED_IDX_W-1:0] led_index;
    logic [9:0]           hue_out;
    logic [7:0]           saturation_out;
    logic [7:0]           led_value;
    logic                 last_led;
  } led_t;

  // One LED worth of work handed from the request sequencer to the pipeline.
  typedef struct packed {
    logic               ring;
    logic [IDX_W-1:0]   idx;
    logic [9:0]         hue;
    logic [7:0]         sat;
    logic [DEG_W-1:0]   centre;
    logic [WIDTH_W-1:0] width;
    logic [7:0]         peak;
    logic               last;
  } item_t;

  typedef logic [C_W-1:0]    c_tab_t    [0:DEG_TURN-1];
  typedef logic [BLUR_W-1:0] blur_tab_t [0:N_WIDTHS-1];
  typedef logic [DEG_W-1:0]  deg_tab_t  [0:2*LEDS_PER_SEGMENT-1];

  // Unsigned long division by shift and subtract, used only to fill the constant tables.
  function automatic longint unsigned udiv_fn(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Q2.16 cosine of an angle given in quarter degrees.
  function automatic int cosq_fn(input int unsigned a_in);
    int unsigned     a;
    logic            neg;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    a   = a_in;
    neg = 1'b0;
    while (a >= 1440) a = a - 1440;
    if (a > 720) a = 1440 - a;
    if (a > 360) begin
      neg = 1'b1;
      a   = 720 - a;
    end
    x   = longint'(a) * RAD_PER_QDEG_Q30;
    x2  = (x * x) >> 30;
    t   = 64'd1 << 30;
    sum = longint'(t);
    for (int k = 1; k <= 6; k++) begin
      t = (t * x2) >> 30;
      t = udiv_fn(t, COS_DIV[k]);
      if ((k & 1) != 0) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 8192) >>> 14;
    return neg ? -int'(sum) : int'(sum);
  endfunction

  // Match value (cos + 1) / 2 in Q16 for a whole-degree difference.
  function automatic c_tab_t build_c_table();
    c_tab_t tab;
    for (int d = 0; d < int'(DEG_TURN); d++) begin
      tab[d] = C_W'((cosq_fn(4 * d) + 65536) >>> 1);
    end
    return tab;
  endfunction

  // Blur factor 1 / (1 - cos(width)) in Q18.14, saturated where the divisor vanishes.
  function automatic blur_tab_t build_blur_table();
    blur_tab_t tab;
    longint    dd;
    for (int w = 0; w < int'(N_WIDTHS); w++) begin
      dd = 65536 - longint'(cosq_fn(w));
      if (dd <= 0) tab[w] = '1;
      else tab[w] = BLUR_W'(udiv_fn(64'd1 << 30, unsigned'(dd)));
    end
    return tab;
  endfunction

  // Angle in degrees of each LED index on a ring.
  function automatic deg_tab_t build_led_deg();
    deg_tab_t    tab;
    int unsigned deg;
    for (int i = 0; i < int'(2 * LEDS_PER_SEGMENT); i++) begin
      deg = LED_FIRST + unsigned'(i) * LED_STEP;
      while (deg >= DEG_TURN) deg = deg - DEG_TURN;
      tab[i] = DEG_W'(deg);
    end
    return tab;
  endfunction

  localparam c_tab_t    C_TABLE    = build_c_table();
  localparam blur_tab_t BLUR_TABLE = build_blur_table();
  localparam deg_tab_t  LED_DEG    = build_led_deg();

endpackage

[rtl/lrsp_if.sv]
// Valid/ready channel interfaces for spotlight requests and per-LED results.
// Depends on lrsp_pkg for the payload types.
`timescale 1ns / 1ps

interface lrsp_req_if;
  import lrsp_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lrsp_led_if;
  import lrsp_pkg::*;
  logic valid;
  logic ready;
  led_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/lrsp_led_pipe.sv]
// Four-stage per-LED pipeline: angle difference, table lookups, blur product, brightness.
// Depends on lrsp_pkg and lrsp_if; the last stage is the output register.
`timescale 1ns / 1ps

module lrsp_led_pipe (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  lrsp_pkg::item_t item,
  output logic            item_ready,
  lrsp_led_if.source      led
);
  import lrsp_pkg::*;

  typedef struct packed {
    logic               ring;
    logic [IDX_W-1:0]   idx;
    logic [9:0]         hue;
    logic [7:0]         sat;
    logic [7:0]         peak;
    logic               wzero;
    logic               last;
  } meta_t;

  logic               v1, v2, v3, v4;
  logic               en1, en2, en3, en4;
  meta_t              meta0, meta1, meta2, meta3;
  logic [DEG_W-1:0]   deg;
  logic [DEG_W-1:0]   diff_next;
  logic [DEG_W-1:0]   diff;
  logic [WIDTH_W-1:0] width1;
  logic [C_W-1:0]     c_q;
  logic [BLUR_W-1:0]  blur_q;
  logic [C_W-1:0]     one_minus_c;
  logic [PROD_W-1:0]  prod;
  logic [M_W-1:0]     m;
  logic               m_big;
  logic [V_W-1:0]     v;
  logic [VP_W-1:0]    vp;
  led_t               out_next;
  led_t               out_q;

  // Each stage moves when it is empty or the stage after it moves.
  assign en4        = !v4 || led.ready;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_ready = en1;

  always_comb begin
    meta0.ring  = item.ring;
    meta0.idx   = item.idx;
    meta0.hue   = item.hue;
    meta0.sat   = item.sat;
    meta0.peak  = item.peak;
    meta0.wzero = (item.width == '0);
    meta0.last  = item.last;
    deg         = LED_DEG[item.idx];
    if (deg >= item.centre) begin
      diff_next = deg - item.centre;
    end else begin
      diff_next = DEG_W'(10'(deg) + 10'(TURN_DEG) - 10'(item.centre));
    end
  end

  always_comb begin
    one_minus_c = QONE - c_q;
    prod        = PROD_W'(one_minus_c) * PROD_W'(blur_q);
  end

  always_comb begin
    m_big = (m >= M_W'(QONE));
    v     = m_big ? '0 : V_W'(QONE - C_W'(m[15:0]));
    vp    = VP_W'(v) * VP_W'(meta3.peak);
    out_next.ring_select    = meta3.ring;
    out_next.led_index      = LED_IDX_W'(meta3.idx);
    out_next.hue_out        = meta3.hue;
    out_next.saturation_out = meta3.sat;
    out_next.led_value      = meta3.wzero ? 8'd0 : vp[23:16];
    out_next.last_led       = meta3.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= item_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      meta1  <= meta0;
      diff   <= diff_next;
      width1 <= item.width;
    end
    if (en2) begin
      meta2  <= meta1;
      c_q    <= C_TABLE[diff];
      blur_q <= BLUR_TABLE[width1];
    end
    if (en3) begin
      meta3 <= meta2;
      m     <= prod[PROD_W-1:14];
    end
    if (en4) begin
      out_q <= out_next;
    end
  end

  assign led.valid = v4;
  assign led.data  = out_q;

endmodule

[rtl/led_ring_spotlight_profile_top.sv]
// LED ring spotlight profile, top level. The LED results of a request follow its transfer
// through the pipeline, one LED result per cycle while the result channel is ready, 12 per
// request (LEDS_PER_SEGMENT). Requests are paced by the single result channel; the next request
// transfers in the cycle the last LED of the current one is issued. Reset (rst, synchronous)
// empties the sequencer and the pipeline; no result is pending afterwards.
// Depends on lrsp_pkg, lrsp_if and lrsp_led_pipe.
`timescale 1ns / 1ps

module led_ring_spotlight_profile_top (
  input  logic      clk,
  input  logic      rst,
  lrsp_req_if.sink  req,
  lrsp_led_if.source led
);
  import lrsp_pkg::*;

  // The sequencer holds one request and walks its LEDs into the pipeline, one per cycle
  // while it accepts them. Each LED entry carries its own valid bit down the pipeline, so a
  // stall on the result side backs up stage by stage without losing or repeating anything.
  logic               busy;
  logic [K_W-1:0]     k;
  logic               k_last;
  logic               req_xfer;
  logic               item_xfer;
  logic               item_ready;
  item_t              item;

  // Captured request fields. The centre is folded into one turn on capture, so a centre
  // of 360 degrees or more wraps around before it reaches the pipeline.
  logic [1:0]         seg;
  logic [9:0]         hue;
  logic [7:0]         sat;
  logic [DEG_W-1:0]   centre;
  logic [WIDTH_W-1:0] width;
  logic [7:0]         peak;
  logic [DEG_W-1:0]   centre_next;

  assign k_last    = (k == K_LAST);
  assign item_xfer = busy && item_ready;

  // A new request is taken when the sequencer is empty, or in the very cycle its last LED
  // moves into the pipeline, so requests follow each other with no gap.
  assign req.ready = !busy || (item_ready && k_last);
  assign req_xfer  = req.valid && req.ready;

  assign centre_next = (req.data.center_angle >= TURN_DEG) ?
                       (req.data.center_angle - TURN_DEG) : req.data.center_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (req_xfer) begin
      busy <= 1'b1;
      k    <= '0;
    end else if (item_xfer) begin
      if (k_last) begin
        busy <= 1'b0;
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      seg    <= req.data.ring_segment;
      hue    <= req.data.hue;
      sat    <= req.data.saturation;
      centre <= centre_next;
      width  <= req.data.spot_width;
      peak   <= req.data.peak_brightness;
    end
  end

  // The second half of a ring starts its LED numbering one segment further on.
  always_comb begin
    item.ring   = seg[1];
    item.idx    = (seg[0] ? HALF_BASE : '0) + IDX_W'(k);
    item.hue    = hue;
    item.sat    = sat;
    item.centre = centre;
    item.width  = width;
    item.peak   = peak;
    item.last   = k_last;
  end

  // Stage 1 finds the angle between LED and centre, stage 2 reads the match and blur
  // tables, stage 3 forms the blurred falloff product, stage 4 scales by the peak and
  // holds the result for the output channel.
  lrsp_led_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .item_valid (busy),
    .item       (item),
    .item_ready (item_ready),
    .led        (led)
  );

endmodule

[tb/tb_led_ring_spotlight_profile_top.sv]
// Self-checking testbench for led_ring_spotlight_profile_top: a directed table followed by
// random requests, each checked LED by LED against a fixed-point spotlight predictor.
// Depends on lrsp_pkg, lrsp_if and the block under test.
`timescale 1ns / 1ps

module tb_led_ring_spotlight_profile_top;
  import lrsp_pkg::*;

  // Geometry and fixed-point constants of the spotlight profile.
  localparam int unsigned FIRST_LED_DEG = 15;
  localparam int unsigned FULL_TURN     = 360;
  localparam int unsigned QDEG_TURN     = 1440;
  localparam longint unsigned Q16_ONE   = 64'd65536;
  localparam longint unsigned QDEG_TO_RAD_Q30 = 64'd4685083;
  localparam int unsigned RANDOM_REQUESTS = 340;
  localparam int unsigned DIRECTED_ROWS   = 20;
  // Random requests in this window are sent and drained with no idling on either side.
  localparam int unsigned STEADY_FIRST = 140;
  localparam int unsigned STEADY_LAST  = 220;

  logic clk;
  logic rst;

  lrsp_req_if req_ch ();
  lrsp_led_if led_ch ();

  led_ring_spotlight_profile_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .led (led_ch)
  );

  // One row of the directed table. Rows marked dark have every LED value known to be zero
  // (zero spread or zero peak), so their results are typed in rather than predicted.
  typedef struct packed {
    logic [1:0]  seg;
    logic [9:0]  hue;
    logic [7:0]  sat;
    logic [8:0]  centre;
    logic [9:0]  width;
    logic [7:0]  peak;
    logic        dark;
  } spot_row_t;

  spot_row_t spot_rows [0:DIRECTED_ROWS-1] = '{
    // All fields at their minimum: zero spread and zero peak.
    '{2'd0,    10'd0,   8'd0,   9'd0, 10'd0,    8'd0, 1'b1},
    // Zero spread with everything else at its maximum, centre past a full turn.
    '{2'd3, 10'd1023, 8'd255, 9'd511, 10'd0,  8'd255, 1'b1},
    // Widest spread but no peak brightness.
    '{2'd1, 10'd1023, 8'd255,  9'd15, 10'd1023, 8'd0, 1'b1},
    // Widest spread, centred exactly on and then opposite the first LED of a half.
    '{2'd0,  10'd512, 8'd128,  9'd15, 10'd1023, 8'd255, 1'b0},
    '{2'd1,    10'd1,   8'd1, 9'd195, 10'd1023, 8'd255, 1'b0},
    // Quarter-turn and half-turn spreads give round blur factors.
    '{2'd2,  10'd300, 8'd200,   9'd0, 10'd360,  8'd255, 1'b0},
    '{2'd3,  10'd700,  8'd77, 9'd359, 10'd720,  8'd255, 1'b0},
    // Centre of exactly one turn wraps to zero.
    '{2'd0,    10'd5,   8'd6, 9'd360, 10'd720,  8'd255, 1'b0},
    '{2'd1,    10'd9,   8'd9, 9'd375, 10'd480,  8'd200, 1'b0},
    '{2'd2, 10'd1000, 8'd250, 9'd511, 10'd240,  8'd255, 1'b0},
    // Tiny spreads give the smallest blur divisors; then wider spreads.
    '{2'd3,    10'd0, 8'd255, 9'd105, 10'd1,    8'd255, 1'b0},
    '{2'd0, 10'd1023,   8'd0,  9'd45, 10'd2,    8'd255, 1'b0},
    '{2'd1,  10'd333,  8'd44, 9'd225, 10'd3,    8'd128, 1'b0},
    '{2'd2,  10'd444,  8'd55, 9'd285, 10'd4,    8'd255, 1'b0},
    '{2'd3,  10'd555,  8'd66, 9'd180, 10'd8,    8'd255, 1'b0},
    '{2'd0,  10'd100, 8'd100,  9'd90, 10'd60,   8'd255, 1'b0},
    '{2'd1,  10'd666,  8'd99, 9'd270, 10'd120,  8'd1,   1'b0},
    '{2'd2,  10'd777,  8'd33,  9'd30, 10'd1022, 8'd254, 1'b0},
    '{2'd3,  10'd888,  8'd11, 9'd345, 10'd512,  8'd255, 1'b0},
    '{2'd0,  10'd999, 8'd222, 9'd256, 10'd960,  8'd170, 1'b0}
  };

  // LED results still owed by the block, oldest first.
  led_t pending_leds [$];

  int unsigned mismatch_count = 0;
  int unsigned requests_sent;
  int unsigned leds_seen = 0;
  int unsigned leds_lit = 0;
  logic        no_idle;

  // Q2.16 cosine of an angle in quarter degrees, from a Taylor series through x^12 in Q30.
  function automatic int cos_q16(input int unsigned qdeg);
    int unsigned     ang;
    logic            flip;
    longint unsigned rad;
    longint unsigned rad_sq;
    longint unsigned term;
    longint          acc;
    int unsigned     n;
    ang  = qdeg % QDEG_TURN;
    flip = 1'b0;
    if (ang > QDEG_TURN / 2) ang = QDEG_TURN - ang;
    if (ang > QDEG_TURN / 4) begin
      flip = 1'b1;
      ang  = QDEG_TURN / 2 - ang;
    end
    rad    = longint'(ang) * QDEG_TO_RAD_Q30;
    rad_sq = (rad * rad) >> 30;
    term   = 64'd1 << 30;
    acc    = longint'(term);
    for (n = 1; n <= 6; n++) begin
      term = (term * rad_sq) >> 30;
      term = term / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 8192) >>> 14;
    return flip ? -int'(acc) : int'(acc);
  endfunction

  // Pushes the LED results that one request causes. Dark rows take the typed-in value zero.
  task automatic predict_spotlight(input req_t r, input logic dark);
    longint          divisor;
    longint unsigned blur;
    longint unsigned match;
    longint unsigned dim;
    int unsigned     idx;
    int unsigned     led_deg;
    int unsigned     diff;
    int unsigned     k;
    led_t            want;
    divisor = longint'(Q16_ONE) - longint'(cos_q16(32'(r.spot_width)));
    if (divisor <= 0) blur = 64'hFFFF_FFFF;
    else blur = (64'd1 << 30) / longint'(divisor);
    for (k = 0; k < LEDS_PER_SEGMENT; k++) begin
      idx = r.ring_segment[0] * LEDS_PER_SEGMENT + k;
      want.ring_select    = r.ring_segment[1];
      want.led_index      = idx[4:0];
      want.hue_out        = r.hue;
      want.saturation_out = r.saturation;
      want.last_led       = (k == LEDS_PER_SEGMENT - 1);
      want.led_value      = '0;
      if (!dark && r.spot_width != 0) begin
        led_deg = (FIRST_LED_DEG + idx * (FULL_TURN / LEDS_PER_SEGMENT)) % FULL_TURN;
        diff    = (led_deg + 2 * FULL_TURN - (r.center_angle % FULL_TURN)) % FULL_TURN;
        match   = longint'(cos_q16(diff * 4) + int'(Q16_ONE)) >> 1;
        dim     = ((Q16_ONE - match) * blur) >> 14;
        if (dim < Q16_ONE) want.led_value = 8'(((Q16_ONE - dim) * r.peak_brightness) >> 16);
      end
      pending_leds.push_back(want);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Offers one request and waits for its transfer. With a chance of about one in four the
  // valid line is first dropped for a random gap, so the gap lands on varied pipeline phases.
  task automatic send_request(input req_t r, input logic dark);
    int unsigned gap;
    if (!no_idle && $urandom_range(99) < 24) begin
      gap = $urandom_range(1, 14);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    // The transfer happened at this edge; the results it causes are now owed.
    predict_spotlight(r, dark);
    requests_sent++;
  endtask

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    r.ring_segment = 2'($urandom_range(0, 3));
    r.hue          = 10'($urandom_range(0, 1023));
    r.saturation   = 8'($urandom_range(0, 255));
    r.peak_brightness = 8'($urandom_range(0, 255));
    // Mostly centres within one turn, some beyond it to exercise the wrap.
    if ($urandom_range(99) < 80) r.center_angle = 9'($urandom_range(0, FULL_TURN - 1));
    else r.center_angle = 9'($urandom_range(FULL_TURN, 511));
    // Narrow spreads are where the profile is sharpest, so they get extra weight.
    pick = $urandom_range(99);
    if (pick < 10) r.spot_width = 10'($urandom_range(0, 8));
    else if (pick < 20) r.spot_width = 10'($urandom_range(9, 64));
    else if (pick < 28) r.spot_width = 10'($urandom_range(960, 1023));
    else r.spot_width = 10'($urandom_range(0, 1023));
    return r;
  endfunction

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: ready is dropped about a quarter of the time except in the steady window.
  // Every LED transfer is checked against the oldest owed result.
  always @(posedge clk) begin
    if (rst) begin
      led_ch.ready <= 1'b0;
    end else begin
      led_ch.ready <= no_idle || ($urandom_range(99) >= 24);
      if (led_ch.valid && led_ch.ready) begin
        leds_seen++;
        if (pending_leds.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: LED transfer with no result owed, index %0d value %0d",
                   $time, led_ch.data.led_index, led_ch.data.led_value);
        end else begin
          if (led_ch.data.led_value != 0) leds_lit++;
          check_field("ring_select", 32'(pending_leds[0].ring_select),
                      32'(led_ch.data.ring_select));
          check_field("led_index", 32'(pending_leds[0].led_index),
                      32'(led_ch.data.led_index));
          check_field("hue_out", 32'(pending_leds[0].hue_out), 32'(led_ch.data.hue_out));
          check_field("saturation_out", 32'(pending_leds[0].saturation_out),
                      32'(led_ch.data.saturation_out));
          check_field("led_value", 32'(pending_leds[0].led_value),
                      32'(led_ch.data.led_value));
          check_field("last_led", 32'(pending_leds[0].last_led), 32'(led_ch.data.last_led));
          void'(pending_leds.pop_front());
        end
      end
    end
  end

  // Request side and run control.
  initial begin
    int unsigned i;
    req_t        r;
    requests_sent  = 0;
    rst            <= 1'b1;
    no_idle        <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.data    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      r.ring_segment    = spot_rows[i].seg;
      r.hue             = spot_rows[i].hue;
      r.saturation      = spot_rows[i].sat;
      r.center_angle    = spot_rows[i].centre;
      r.spot_width      = spot_rows[i].width;
      r.peak_brightness = spot_rows[i].peak;
      send_request(r, spot_rows[i].dark);
    end

    // Random requests, with one stretch free of idling on both sides.
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      no_idle <= (i >= STEADY_FIRST && i < STEADY_LAST);
      send_request(random_request(), 1'b0);
    end
    req_ch.valid <= 1'b0;
    no_idle      <= 1'b0;

    // Drain every owed result, then keep watching for stray transfers.
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d spotlight requests (%0d from the directed table) on all ring halves.",
             requests_sent, DIRECTED_ROWS);
    $display("Checked %0d LED transfers, %0d of them lit, with stalls on both channels.",
             leds_seen, leds_lit);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
